>>> hdl/csc_pkg.sv
// Shared definitions for the calendar season classifier.
// Season codes, stage count, latency, widths and date_t; used by the RTL and its checker.
// No dependencies.
`default_nettype none

package csc_pkg;

    // Season codes on the season port
    localparam logic [2:0] SC_NEW_YEAR  = 3'd0;
    localparam logic [2:0] SC_CHRISTMAS = 3'd1;
    localparam logic [2:0] SC_HALLOWEEN = 3'd2;
    localparam logic [2:0] SC_EASTER    = 3'd3;
    localparam logic [2:0] SC_WINTER    = 3'd4;
    localparam logic [2:0] SC_SPRING    = 3'd5;
    localparam logic [2:0] SC_SUMMER    = 3'd6;
    localparam logic [2:0] SC_AUTUMN    = 3'd7;

    // Pipeline depth ahead of the output register: input register and ten working stages
    localparam int unsigned NUM_STAGES = 11;
    // Clock edges from the accepting edge to the edge that takes the result
    localparam int unsigned LATENCY    = NUM_STAGES + 1;

    // Year, month, day widths
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;

    // Date carried alongside the Easter computation
    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

endpackage : csc_pkg

`default_nettype wire

>>> hdl/calendar_season_classifier.sv
// Calendar season classifier: pipelined Easter computus and season decode.
// Depends on csc_pkg (season codes, stage count, date_t).
`default_nettype none

// Accepts one date per clock cycle (busy is never raised) and returns its
// result from the output register, marked by done for one cycle. Ahead of
// it lies the eleven-register pipeline that carries the Easter computation:
// the divisions by 19, 100, 25, 3, 30 and 7 are reciprocal multiplies, and
// where a remainder is needed it is taken in the next stage. The receiver
// cannot stall, so the pipeline advances every cycle and results leave in
// the order their words arrived.
module calendar_season_classifier (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [csc_pkg::YEAR_W-1:0]   year,
    input  wire logic [csc_pkg::MONTH_W-1:0]  month,
    input  wire logic [csc_pkg::DAY_W-1:0]    day,
    output logic                              done,
    output logic [2:0]                        season,
    output logic [2:0]                        easter_month,
    output logic [4:0]                        easter_day
);

    // Reciprocal constants: q = (x * RECIP) >> SHIFT, exact over the value range
    localparam logic [15:0] RECIP19  = 16'd55189;  // year / 19, shift 20
    localparam logic [12:0] RECIP100 = 13'd5243;   // year / 100, shift 19
    localparam logic [5:0]  RECIP25  = 6'd41;      // (cent + 8) / 25, shift 10
    localparam logic [7:0]  RECIP3   = 8'd171;     // lunar term / 3, shift 9
    localparam logic [10:0] RECIP30  = 11'd1093;   // epact sum / 30, shift 15
    localparam logic [7:0]  RECIP7   = 8'd147;     // weekday sum / 7, shift 10

    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;
    localparam logic [3:0] MON_JAN = 4'd1;

    localparam int unsigned LAST = csc_pkg::NUM_STAGES - 1;

    // Valid bits and the date shift line
    logic [LAST:0]          vld_reg;
    csc_pkg::date_t         dt_reg [0:LAST];
    logic                   done_reg;

    // Stage 0: captured year
    logic [13:0] yr0_reg;

    // Stage 1: year / 19 and year / 100
    logic [29:0] q19_prod;
    logic [26:0] cent_prod;
    logic [13:0] yr1_reg;
    logic [9:0]  q19_reg;
    logic [7:0]  cent1_reg;

    // Stage 2: golden number, year in century, solar correction
    logic [13:0] golden_full;
    logic [13:0] yic_full;
    logic [8:0]  corr_arg;
    logic [14:0] corr_prod;
    logic [4:0]  golden2_reg;
    logic [6:0]  yic2_reg;
    logic [7:0]  cent2_reg;
    logic [2:0]  corr2_reg;

    // Stage 3: lunar correction
    logic [7:0]  lun_arg;
    logic [15:0] lun_prod;
    logic [4:0]  golden3_reg;
    logic [6:0]  yic3_reg;
    logic [7:0]  cent3_reg;
    logic [5:0]  lun3_reg;

    // Stage 4: epact sum before reduction
    logic [9:0]  ep_raw_next;
    logic [9:0]  ep_raw4_reg;
    logic [4:0]  golden4_reg;
    logic [6:0]  yic4_reg;
    logic [1:0]  cr4_reg;

    // Stage 5: epact sum / 30
    logic [20:0] q30_prod;
    logic [9:0]  ep_raw5_reg;
    logic [4:0]  q30_reg;
    logic [4:0]  golden5_reg;
    logic [6:0]  yic5_reg;
    logic [1:0]  cr5_reg;

    // Stage 6: epact and weekday sum
    logic [9:0]  epact_full;
    logic [7:0]  wd_raw_full;
    logic [4:0]  epact6_reg;
    logic [6:0]  wd_raw6_reg;
    logic [4:0]  golden6_reg;

    // Stage 7: weekday sum / 7
    logic [14:0] q7_prod;
    logic [3:0]  q7_reg;
    logic [4:0]  epact7_reg;
    logic [6:0]  wd_raw7_reg;
    logic [4:0]  golden7_reg;

    // Stage 8: weekday and adjustment sum
    logic [6:0]  wd_full;
    logic [2:0]  wd8_reg;
    logic [4:0]  epact8_reg;
    logic [9:0]  adj_raw8_reg;

    // Stage 9: day number counted from 1 March, plus 92
    logic [7:0]  sum_next;
    logic [7:0]  sum9_reg;

    // Stage 10: Easter Sunday
    logic        emon_apr;
    logic [7:0]  eday_full;
    logic [2:0]  emon10_reg;
    logic [4:0]  eday10_reg;

    // Output stage
    logic [5:0]  pos;
    logic [5:0]  epos;
    logic        in_window;
    logic [2:0]  season_next;
    logic [2:0]  season_reg;
    logic [2:0]  emon_out_reg;
    logic [4:0]  eday_out_reg;

    // The pipeline never stalls
    assign busy = 1'b0;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[LAST-1:0], start & ~busy};
            done_reg <= vld_reg[LAST];
        end
    end

    // Date shift line
    always_ff @(posedge clk)
    begin
        dt_reg[0] <= '{month: month, day: day};
        for (int i = 1; i <= LAST; i++)
        begin
            dt_reg[i] <= dt_reg[i-1];
        end
    end

    // Stage 1 arithmetic: reciprocal multiplies
    assign q19_prod  = 30'(yr0_reg) * 30'(RECIP19);
    assign cent_prod = 27'(yr0_reg) * 27'(RECIP100);

    // Stage 2 arithmetic: remainders and solar correction
    assign golden_full = yr1_reg - 14'(q19_reg) * 14'd19;
    assign yic_full    = yr1_reg - 14'(cent1_reg) * 14'd100;
    assign corr_arg    = 9'(cent1_reg) + 9'd8;
    assign corr_prod   = 15'(corr_arg) * 15'(RECIP25);

    // Stage 3 arithmetic: lunar correction
    assign lun_arg  = cent2_reg - 8'(corr2_reg) + 8'd1;
    assign lun_prod = 16'(lun_arg) * 16'(RECIP3);

    // Stage 4 arithmetic: 19g + c - c/4 - l + 15
    assign ep_raw_next = 10'(golden3_reg) * 10'd19 + 10'(cent3_reg)
                       - 10'(cent3_reg[7:2]) - 10'(lun3_reg) + 10'd15;

    // Stage 5 arithmetic
    assign q30_prod = 21'(ep_raw4_reg) * 21'(RECIP30);

    // Stage 6 arithmetic: epact and 32 + 2e + 2i - h - k
    assign epact_full  = ep_raw5_reg - 10'(q30_reg) * 10'd30;
    assign wd_raw_full = 8'd32 + {5'd0, cr5_reg, 1'b0} + {2'd0, yic5_reg[6:2], 1'b0}
                       - 8'(epact_full[4:0]) - 8'(yic5_reg[1:0]);

    // Stage 7 arithmetic
    assign q7_prod = 15'(wd_raw6_reg) * 15'(RECIP7);

    // Stage 8 arithmetic
    assign wd_full = wd_raw7_reg - 7'(q7_reg) * 7'd7;

    // Stage 9 arithmetic: adjustment is at most one, so a compare does
    assign sum_next = 8'(epact8_reg) + 8'(wd8_reg) + 8'd114
                    - ((adj_raw8_reg >= 10'd451) ? 8'd7 : 8'd0);

    // Stage 10 arithmetic: sum / 31 is 3 or 4
    assign emon_apr  = (sum9_reg >= 8'd124);
    assign eday_full = sum9_reg - (emon_apr ? 8'd123 : 8'd92);

    // Easter window: Good Friday through Easter Monday, by day from 1 March
    assign pos  = (dt_reg[LAST].month == MON_MAR) ? 6'(dt_reg[LAST].day)
                                                  : 6'd31 + 6'(dt_reg[LAST].day);
    assign epos = (emon10_reg == 3'(MON_MAR)) ? 6'(eday10_reg) : 6'd31 + 6'(eday10_reg);
    assign in_window = ((dt_reg[LAST].month == MON_MAR) || (dt_reg[LAST].month == MON_APR))
                    && (7'(pos) + 7'd2 >= 7'(epos)) && (7'(pos) <= 7'(epos) + 7'd1);

    // Season decode in priority order
    always_comb
    begin
        if ((dt_reg[LAST].month == MON_DEC && dt_reg[LAST].day == 5'd31)
            || (dt_reg[LAST].month == MON_JAN && dt_reg[LAST].day == 5'd1))
        begin
            season_next = csc_pkg::SC_NEW_YEAR;
        end
        else if (dt_reg[LAST].month == MON_DEC && dt_reg[LAST].day >= 5'd24
                 && dt_reg[LAST].day <= 5'd26)
        begin
            season_next = csc_pkg::SC_CHRISTMAS;
        end
        else if ((dt_reg[LAST].month == MON_OCT && dt_reg[LAST].day == 5'd31)
                 || (dt_reg[LAST].month == MON_NOV && dt_reg[LAST].day == 5'd1))
        begin
            season_next = csc_pkg::SC_HALLOWEEN;
        end
        else if (in_window)
        begin
            season_next = csc_pkg::SC_EASTER;
        end
        else
        begin
            case (dt_reg[LAST].month) inside
                [4'd3:4'd5]:  season_next = csc_pkg::SC_SPRING;
                [4'd6:4'd8]:  season_next = csc_pkg::SC_SUMMER;
                [4'd9:4'd11]: season_next = csc_pkg::SC_AUTUMN;
                default:      season_next = csc_pkg::SC_WINTER;
            endcase
        end
    end

    // Payload registers of every stage
    always_ff @(posedge clk)
    begin
        // stage 0
        yr0_reg      <= year;
        // stage 1
        yr1_reg      <= yr0_reg;
        q19_reg      <= q19_prod[20 +: 10];
        cent1_reg    <= cent_prod[19 +: 8];
        // stage 2
        golden2_reg  <= golden_full[4:0];
        yic2_reg     <= yic_full[6:0];
        cent2_reg    <= cent1_reg;
        corr2_reg    <= corr_prod[10 +: 3];
        // stage 3
        golden3_reg  <= golden2_reg;
        yic3_reg     <= yic2_reg;
        cent3_reg    <= cent2_reg;
        lun3_reg     <= lun_prod[9 +: 6];
        // stage 4
        ep_raw4_reg  <= ep_raw_next;
        golden4_reg  <= golden3_reg;
        yic4_reg     <= yic3_reg;
        cr4_reg      <= cent3_reg[1:0];
        // stage 5
        ep_raw5_reg  <= ep_raw4_reg;
        q30_reg      <= q30_prod[15 +: 5];
        golden5_reg  <= golden4_reg;
        yic5_reg     <= yic4_reg;
        cr5_reg      <= cr4_reg;
        // stage 6
        epact6_reg   <= epact_full[4:0];
        wd_raw6_reg  <= wd_raw_full[6:0];
        golden6_reg  <= golden5_reg;
        // stage 7
        q7_reg       <= q7_prod[10 +: 4];
        epact7_reg   <= epact6_reg;
        wd_raw7_reg  <= wd_raw6_reg;
        golden7_reg  <= golden6_reg;
        // stage 8
        wd8_reg      <= wd_full[2:0];
        epact8_reg   <= epact7_reg;
        adj_raw8_reg <= 10'(golden7_reg) + 10'(epact7_reg) * 10'd11
                      + 10'(wd_full[2:0]) * 10'd22;
        // stage 9
        sum9_reg     <= sum_next;
        // stage 10
        emon10_reg   <= emon_apr ? 3'(MON_APR) : 3'(MON_MAR);
        eday10_reg   <= eday_full[4:0];
        // output
        season_reg   <= season_next;
        emon_out_reg <= emon10_reg;
        eday_out_reg <= eday10_reg;
    end

    assign done         = done_reg;
    assign season       = season_reg;
    assign easter_month = emon_out_reg;
    assign easter_day   = eday_out_reg;

endmodule : calendar_season_classifier

`default_nettype wire

>>> hdl/csc_checker.sv
// Port-level checker for the calendar season classifier, with its bind.
// Depends on csc_pkg (season codes, latency).
`default_nettype none

module csc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic [csc_pkg::YEAR_W-1:0]   year,
    input wire logic [csc_pkg::MONTH_W-1:0]  month,
    input wire logic [csc_pkg::DAY_W-1:0]    day,
    input wire logic                         done,
    input wire logic [2:0]                   season,
    input wire logic [2:0]                   easter_month,
    input wire logic [4:0]                   easter_day
);

    // Every accepted word gives its result after the fixed latency
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(csc_pkg::LATENCY) done)
        else $error("result strobe missing after accepted word");

    // No result without a word accepted at the matching edge
    a_done_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, csc_pkg::LATENCY))
        else $error("result strobe without accepted word");

    // Easter Sunday lies between 22 March and 25 April
    a_easter_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((easter_month == 3'd3 && easter_day >= 5'd22)
               || (easter_month == 3'd4 && easter_day <= 5'd25)))
        else $error("Easter Sunday out of range");

    // The Easter season only comes from a March or April date
    a_easter_month: assert property (@(posedge clk) disable iff (!rst_n)
        (done && season == csc_pkg::SC_EASTER)
            |-> ($past(month, csc_pkg::LATENCY) == 4'd3
              || $past(month, csc_pkg::LATENCY) == 4'd4))
        else $error("Easter season for a date outside March and April");

endmodule : csc_checker

bind calendar_season_classifier csc_checker u_csc_checker (.*);

`default_nettype wire

>>> dv/calendar_season_classifier_test.sv
// Self-checking bench for calendar_season_classifier: date words in, season and
// Easter Sunday checked against an in-bench computus. Depends on csc_pkg and the RTL.
`timescale 1ns / 100ps

module calendar_season_classifier_test;

    localparam int unsigned YEAR_W      = csc_pkg::YEAR_W;
    localparam int unsigned MONTH_W     = csc_pkg::MONTH_W;
    localparam int unsigned DAY_W       = csc_pkg::DAY_W;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned NUM_RANDOM  = 450;

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        bit                 drain;   // marker: hold off until all results are back
    } date_word_t;

    typedef struct {
        logic [2:0] season;
        logic [2:0] emon;
        logic [4:0] eday;
    } season_word_t;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [YEAR_W-1:0]  year  = '0;
    logic [MONTH_W-1:0] month = '0;
    logic [DAY_W-1:0]   day   = '0;
    logic               busy;
    logic               done;
    logic [2:0]         season;
    logic [2:0]         easter_month;
    logic [4:0]         easter_day;

    date_word_t   pending_dates[$];
    season_word_t expected_seasons[$];
    int unsigned  mismatches  = 0;
    int unsigned  cycle_count = 0;
    int           gap_left    = 0;
    int           burst_left  = 0;

    calendar_season_classifier i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .year         (year),
        .month        (month),
        .day          (day),
        .done         (done),
        .season       (season),
        .easter_month (easter_month),
        .easter_day   (easter_day)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Anonymous Gregorian computus; returns Easter Sunday as month and day
    function automatic season_word_t easter_of_year(input int y);
        season_word_t r;
        int golden, cent, yic, cq, cr, corr, lun, epact, yq, yr4, wd, adj, total;
        golden = y % 19;
        cent   = y / 100;
        yic    = y % 100;
        cq     = cent / 4;
        cr     = cent % 4;
        corr   = (cent + 8) / 25;
        lun    = (cent - corr + 1) / 3;
        epact  = (19 * golden + cent - cq - lun + 15) % 30;
        yq     = yic / 4;
        yr4    = yic % 4;
        wd     = (32 + 2 * cr + 2 * yq - epact - yr4) % 7;
        adj    = (golden + 11 * epact + 22 * wd) / 451;
        total  = epact + wd - 7 * adj + 114;
        r.season = csc_pkg::SC_WINTER;
        r.emon   = 3'(total / 31);
        r.eday   = 5'(total % 31 + 1);
        return r;
    endfunction

    // Season of a date, holidays first, then Easter window, then by month
    function automatic season_word_t classify_date(input date_word_t w);
        season_word_t r;
        int m, d, pos, epos;
        r = easter_of_year(int'(w.year));
        m = int'(w.month);
        d = int'(w.day);
        pos  = (m == 3) ? d : 31 + d;
        epos = (r.emon == 3) ? int'(r.eday) : 31 + int'(r.eday);
        if ((m == 12 && d == 31) || (m == 1 && d == 1))
            r.season = csc_pkg::SC_NEW_YEAR;
        else if (m == 12 && d >= 24 && d <= 26)
            r.season = csc_pkg::SC_CHRISTMAS;
        else if ((m == 10 && d == 31) || (m == 11 && d == 1))
            r.season = csc_pkg::SC_HALLOWEEN;
        else if ((m == 3 || m == 4) && pos + 2 >= epos && pos <= epos + 1)
            r.season = csc_pkg::SC_EASTER;
        else if (m >= 3 && m <= 5)
            r.season = csc_pkg::SC_SPRING;
        else if (m >= 6 && m <= 8)
            r.season = csc_pkg::SC_SUMMER;
        else if (m >= 9 && m <= 11)
            r.season = csc_pkg::SC_AUTUMN;
        else
            r.season = csc_pkg::SC_WINTER;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and bursts with none
    function automatic int next_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3)
        begin
            burst_left = $urandom_range(40, 20);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic add_date(input int y, input int m, input int d);
        date_word_t w;
        w.year  = YEAR_W'(y);
        w.month = MONTH_W'(m);
        w.day   = DAY_W'(d);
        w.drain = 1'b0;
        pending_dates.push_back(w);
    endtask

    task automatic add_drain();
        date_word_t w;
        w = '{default: '0};
        w.drain = 1'b1;
        pending_dates.push_back(w);
    endtask

    // Random date: weighted towards Easter and the holidays; some months and days out of range
    task automatic add_random_date();
        season_word_t e;
        int y, m, d, r, p;
        int edge_days[9] = '{1, 2, 23, 24, 25, 26, 27, 30, 31};
        int edge_months[4] = '{10, 11, 12, 1};
        y = ($urandom_range(99) < 15) ? $urandom_range(16383) : $urandom_range(9999, 1583);
        r = $urandom_range(99);
        if (r < 35)
        begin
            e = easter_of_year(y);
            p = ((e.emon == 3) ? int'(e.eday) : 31 + int'(e.eday)) + $urandom_range(8) - 4;
            m = (p <= 31) ? 3 : 4;
            d = (p <= 31) ? p : p - 31;
        end
        else if (r < 50)
        begin
            m = edge_months[$urandom_range(3)];
            d = edge_days[$urandom_range(8)];
        end
        else if (r < 90)
        begin
            m = $urandom_range(12, 1);
            d = $urandom_range(31, 1);
        end
        else
        begin
            m = $urandom_range(15);
            d = $urandom_range(31);
        end
        add_date(y, m, d);
    endtask

    // Driver: one date word per accepted start, gaps between words
    always @(posedge clk)
    begin : drive_dates
        date_word_t w;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                w.year  = year;
                w.month = month;
                w.day   = day;
                w.drain = 1'b0;
                expected_seasons.push_back(classify_date(w));
            end
            if (start && busy)
            begin
                // word held until taken
            end
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pending_dates.size() == 0)
                start <= 1'b0;
            else if (pending_dates[0].drain)
            begin
                start <= 1'b0;
                if (expected_seasons.size() == 0)
                    void'(pending_dates.pop_front());
            end
            else
            begin
                w = pending_dates.pop_front();
                year     <= w.year;
                month    <= w.month;
                day      <= w.day;
                start    <= 1'b1;
                gap_left = next_gap();
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        season_word_t exp_w;
        if (rst_n && done)
        begin
            if (expected_seasons.size() == 0)
            begin
                $display("%0t: result with nothing expected: season %0d, easter %0d/%0d",
                         $time, season, easter_month, easter_day);
                mismatches++;
            end
            else
            begin
                exp_w = expected_seasons.pop_front();
                if (season !== exp_w.season)
                begin
                    $display("%0t: season mismatch: expected %0d, got %0d",
                             $time, exp_w.season, season);
                    mismatches++;
                end
                if (easter_month !== exp_w.emon)
                begin
                    $display("%0t: easter_month mismatch: expected %0d, got %0d",
                             $time, exp_w.emon, easter_month);
                    mismatches++;
                end
                if (easter_day !== exp_w.eday)
                begin
                    $display("%0t: easter_day mismatch: expected %0d, got %0d",
                             $time, exp_w.eday, easter_day);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        // Directed: holidays and their neighbours
        add_date(2024, 12, 31);
        add_date(2024, 1, 1);
        add_date(2024, 12, 24);
        add_date(2024, 12, 26);
        add_date(2024, 12, 23);
        add_date(2024, 12, 27);
        add_date(2024, 10, 31);
        add_date(2024, 11, 1);
        // Easter window edges; 2024 Easter Sunday is 31 March
        add_date(2024, 3, 28);
        add_date(2024, 3, 29);
        add_date(2024, 3, 30);
        add_date(2024, 4, 1);
        add_date(2024, 4, 2);
        add_date(2024, 4, 0);       // day zero of April sits at 31 March
        add_date(2024, 4, 31);
        // Years of the earliest and latest Easter Sunday, around their window edges
        add_date(1818, 3, 20);
        add_date(2038, 4, 26);
        add_date(2038, 4, 27);
        // Months outside the calendar, impossible day, year extremes, ordinary dates
        add_date(0, 0, 0);
        add_date(16383, 15, 31);
        add_date(1583, 13, 5);
        add_date(9999, 2, 30);
        add_date(2001, 5, 15);
        add_date(2001, 7, 4);
        add_date(2001, 9, 30);
        add_drain();

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == NUM_RANDOM / 3 || i == 2 * NUM_RANDOM / 3)
                add_drain();
            add_random_date();
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_dates.size() != 0 || start || expected_seasons.size() != 0);
        repeat (csc_pkg::LATENCY + 4) @(posedge clk);

        if (mismatches == 0 && expected_seasons.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
hdl/csc_pkg.sv
hdl/calendar_season_classifier.sv
hdl/csc_checker.sv
dv/calendar_season_classifier_test.sv
